// ===== hw/rtl/smf_pkg.sv =====
`timescale 1ns / 1ps

package smf_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_FIELD_SCALE   = 2'd0,
    REG_REF_RADIUS    = 2'd1,
    REG_ROTATION_RATE = 2'd2,
    REG_WIND_SPEED    = 2'd3
  } reg_idx_e;

  localparam int unsigned POS_W = 32;
  localparam int unsigned QBITS = 62;   // quotient bits of the wide dividers
  localparam int unsigned MAG_W = 62;   // width of a held intermediate magnitude

  // Intermediate magnitudes are held at 2^61
  localparam logic [MAG_W-1:0] CAP = {1'b1, 61'd0};

  // Register values after reset (1.0 in Q16.16, or zero)
  localparam logic [31:0] FIELD_SCALE_RST   = 32'd65536;
  localparam logic [30:0] REF_RADIUS_RST    = 31'd65536;
  localparam logic [31:0] ROTATION_RATE_RST = 32'd0;
  localparam logic [30:0] WIND_SPEED_RST    = 31'd65536;

  typedef struct packed {
    logic [2:0][POS_W-1:0] pm;
    logic [2:0]            neg;
    logic                  org;
    logic [63:0]           r2;
  } sq_side_t;

  function automatic logic signed [63:0] apply_sign(logic [MAG_W-1:0] m, logic neg);
    logic signed [63:0] v;
    v = signed'(64'(m));
    return neg ? -v : v;
  endfunction

endpackage

// ===== hw/rtl/smf_div.sv =====
`timescale 1ns / 1ps

// Pipelined restoring divider, one quotient bit per stage.
// Flags overflow when the quotient does not fit in QW bits.
module smf_div #(
  parameter int unsigned DW = 64,
  parameter int unsigned VW = 64,
  parameter int unsigned QW = 62,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QW-1:0] quot_o,
  output logic          ovf_o,
  output logic [SW-1:0] side_o
);

  localparam int unsigned HW = DW - QW;
  localparam int unsigned MW = (HW > VW) ? HW : VW;

  logic [MW-1:0] hi_x;
  logic [MW-1:0] dvs_x;
  logic          ovf;

  logic [QW:0]   vld_q;
  logic [VW-1:0] rem_q [QW+1];
  logic [QW-1:0] dq_q  [QW+1];
  logic [VW-1:0] dvs_q [QW+1];
  logic          ovf_q [QW+1];
  logic [SW-1:0] side_q[QW+1];

  assign hi_x  = MW'(dividend_i[DW-1:QW]);
  assign dvs_x = MW'(divisor_i);
  assign ovf   = hi_x >= dvs_x;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QW-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= ovf ? '0 : VW'(hi_x);
      dq_q[0]   <= dividend_i[QW-1:0];
      dvs_q[0]  <= divisor_i;
      ovf_q[0]  <= ovf;
      side_q[0] <= side_i;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_step
    logic [VW:0] t;
    logic [VW:0] dsub;
    logic        ge;

    assign t    = {rem_q[k-1], dq_q[k-1][QW-1]};
    assign ge   = t >= {1'b0, dvs_q[k-1]};
    assign dsub = t - {1'b0, dvs_q[k-1]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? dsub[VW-1:0] : t[VW-1:0];
        dq_q[k]   <= {dq_q[k-1][QW-2:0], ge};
        dvs_q[k]  <= dvs_q[k-1];
        ovf_q[k]  <= ovf_q[k-1];
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign valid_o = vld_q[QW];
  assign quot_o  = dq_q[QW];
  assign ovf_o   = ovf_q[QW];
  assign side_o  = side_q[QW];

endmodule

// ===== hw/rtl/spiral_magnetic_field_eval.sv =====
`timescale 1ns / 1ps

// Archimedean spiral field evaluator. Each request carries one position (x, y, z) in signed
// fixed point with FRAC_BITS fraction bits and yields one field vector: a radial part
// R0^2/r^2 along the unit vector and an azimuthal part -Omega*R0^2*(rho/r)/(r*Vw) along
// (-y/r, x/r, 0), negated for z < 0 and scaled by B0. Components saturate to 32 bits; tuser
// flags the origin (all-zero result) and any saturation, including an intermediate held at
// 2^61. The block is a fully pipelined datapath that takes one request every cycle unless the
// result side stalls; most of its stages are the 32-step square roots (both lanes side by
// side), the FRAC_BITS+1 step unit-ratio dividers and two 62-step restoring dividers in
// series. A stall on the result side freezes the whole pipe. The user must write registers
// through cfg_* only while no request is in flight; the block itself does not enforce it.
module spiral_magnetic_field_eval #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request: pos_x [31:0], pos_y [63:32], pos_z [95:64]
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,
  // result: field_x [31:0], field_y [63:32], field_z [95:64]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,
  // result flags: at_origin [0], clipped [1]
  output logic [1:0]  m_axis_tuser,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  localparam int unsigned UW = FRAC_BITS + 1;   // unit ratios are at most 1.0
  localparam int unsigned PW = 63 + FRAC_BITS;  // R0^2 * s
  localparam int unsigned VF = 31 + FRAC_BITS;  // Vw scaled by 2^F
  localparam int unsigned TW = 62 + UW;         // held magnitude times unit ratio
  localparam int unsigned QB = smf_pkg::QBITS;
  localparam int unsigned MG = smf_pkg::MAG_W;
  localparam int unsigned OW = 95 - FRAC_BITS;  // final magnitude after the shift

  typedef struct packed {
    logic [MG-1:0]         c1;
    logic [2:0][UW-1:0]    um;
    logic [2:0]            neg;
    logic                  org;
    logic                  clip;
  } c2_side_t;

  // ---------------------------------------------------------------- configuration
  logic [31:0] b0_q;
  logic [30:0] r0_q;
  logic [31:0] om_q;
  logic [30:0] vw_q;
  logic [61:0] r0sq_q;
  logic [VF-1:0] vwf_q;
  logic [31:0] b0mag;
  logic [31:0] ommag;
  logic        c2neg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_q <= smf_pkg::FIELD_SCALE_RST;
      r0_q <= smf_pkg::REF_RADIUS_RST;
      om_q <= smf_pkg::ROTATION_RATE_RST;
      vw_q <= smf_pkg::WIND_SPEED_RST;
    end else if (cfg_we_i) begin
      case (smf_pkg::reg_idx_e'(cfg_idx_i))
        smf_pkg::REG_FIELD_SCALE:   b0_q <= cfg_wdata_i;
        smf_pkg::REG_REF_RADIUS:    r0_q <= cfg_wdata_i[30:0];
        smf_pkg::REG_ROTATION_RATE: om_q <= cfg_wdata_i;
        smf_pkg::REG_WIND_SPEED:    vw_q <= cfg_wdata_i[30:0];
        default: ;
      endcase
    end
  end

  // Derived constants follow the registers in the next cycle; a request needs them much later.
  always_ff @(posedge clk_i) begin
    r0sq_q <= 62'(r0_q) * 62'(r0_q);
    vwf_q  <= {((vw_q == '0) ? 31'd1 : vw_q), {FRAC_BITS{1'b0}}};  // zero wind acts as 1 LSB
  end

  assign b0mag = b0_q[31] ? 32'(-b0_q) : b0_q;
  assign ommag = om_q[31] ? 32'(-om_q) : om_q;
  assign c2neg = ~om_q[31];  // azimuthal coefficient carries minus the sign of Omega

  // ---------------------------------------------------------------- flow control
  // Advance every stage together; hold all of them while the result waits.
  logic adv;
  logic out_vld_q;

  assign adv           = ~out_vld_q | m_axis_tready;
  assign s_axis_tready = adv;

  // ---------------------------------------------------------------- magnitudes and squares
  logic                 s1_vld_q, s2_vld_q;
  logic [2:0][31:0]     s1_pm_q, s2_pm_q;
  logic [2:0]           s1_neg_q, s2_neg_q;
  logic                 s1_org_q, s2_org_q;
  logic [2:0][63:0]     s2_sq_q;
  logic [2:0][31:0]     in_pm;
  logic [2:0]           in_neg;

  for (genvar i = 0; i < 3; i++) begin : g_in
    logic [31:0] p;
    assign p         = s_axis_tdata[32*i +: 32];
    assign in_neg[i] = p[31];
    assign in_pm[i]  = p[31] ? 32'(-p) : p;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_pm_q  <= in_pm;
      s1_neg_q <= in_neg;
      s1_org_q <= (s_axis_tdata == '0);
      s2_pm_q  <= s1_pm_q;
      s2_neg_q <= s1_neg_q;
      s2_org_q <= s1_org_q;
      for (int i = 0; i < 3; i++) begin
        s2_sq_q[i] <= 64'(s1_pm_q[i]) * 64'(s1_pm_q[i]);
      end
    end
  end

  // ---------------------------------------------------------------- square roots
  // Lane 0 takes r^2, lane 1 takes rho^2; one root bit per stage.
  logic [32:0]          rt_vld_q;
  logic [1:0][63:0]     rt_n_q   [33];
  logic [1:0][34:0]     rt_rem_q [33];
  logic [1:0][31:0]     rt_res_q [33];
  smf_pkg::sq_side_t    rt_side_q[33];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rt_n_q[0][0]       <= s2_sq_q[0] + s2_sq_q[1] + s2_sq_q[2];
      rt_n_q[0][1]       <= s2_sq_q[0] + s2_sq_q[1];
      rt_rem_q[0]        <= '0;
      rt_res_q[0]        <= '0;
      rt_side_q[0].pm    <= s2_pm_q;
      rt_side_q[0].neg   <= s2_neg_q;
      rt_side_q[0].org   <= s2_org_q;
      rt_side_q[0].r2    <= s2_sq_q[0] + s2_sq_q[1] + s2_sq_q[2];
    end
  end

  for (genvar k = 1; k <= 32; k++) begin : g_rt
    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [36:0] t;
      logic [36:0] trial;
      logic        ge;

      assign t     = {rt_rem_q[k-1][l], rt_n_q[k-1][l][63:62]};
      assign trial = {3'b000, rt_res_q[k-1][l], 2'b01};
      assign ge    = t >= trial;

      always_ff @(posedge clk_i) begin
        if (adv) begin
          rt_rem_q[k][l] <= ge ? 35'(t - trial) : t[34:0];
          rt_res_q[k][l] <= {rt_res_q[k-1][l][30:0], ge};
          rt_n_q[k][l]   <= {rt_n_q[k-1][l][61:0], 2'b00};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        rt_side_q[k] <= rt_side_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------- unit ratios
  logic [31:0]   rt_r, rt_rho, rt_rdiv;
  logic [3:0]    us_vld;
  logic [3:0]    us_ovf;
  logic [2:0][UW-1:0] us_um;
  logic [UW-1:0] us_s;
  logic [3:0]    us_negorg;
  logic [31:0]   us_r2_hi, us_r2_lo, us_r;

  assign rt_r    = rt_res_q[32][0];
  assign rt_rho  = rt_res_q[32][1];
  assign rt_rdiv = rt_side_q[32].org ? 32'd1 : rt_r;

  smf_div #(.DW(32 + FRAC_BITS), .VW(32), .QW(UW), .SW(4)) u_div_ux (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(rt_vld_q[32]),
    .dividend_i({rt_side_q[32].pm[0], {FRAC_BITS{1'b0}}}), .divisor_i(rt_rdiv),
    .side_i({rt_side_q[32].neg, rt_side_q[32].org}),
    .valid_o(us_vld[0]), .quot_o(us_um[0]), .ovf_o(us_ovf[0]), .side_o(us_negorg)
  );

  smf_div #(.DW(32 + FRAC_BITS), .VW(32), .QW(UW), .SW(32)) u_div_uy (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(rt_vld_q[32]),
    .dividend_i({rt_side_q[32].pm[1], {FRAC_BITS{1'b0}}}), .divisor_i(rt_rdiv),
    .side_i(rt_side_q[32].r2[63:32]),
    .valid_o(us_vld[1]), .quot_o(us_um[1]), .ovf_o(us_ovf[1]), .side_o(us_r2_hi)
  );

  smf_div #(.DW(32 + FRAC_BITS), .VW(32), .QW(UW), .SW(32)) u_div_uz (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(rt_vld_q[32]),
    .dividend_i({rt_side_q[32].pm[2], {FRAC_BITS{1'b0}}}), .divisor_i(rt_rdiv),
    .side_i(rt_side_q[32].r2[31:0]),
    .valid_o(us_vld[2]), .quot_o(us_um[2]), .ovf_o(us_ovf[2]), .side_o(us_r2_lo)
  );

  smf_div #(.DW(32 + FRAC_BITS), .VW(32), .QW(UW), .SW(32)) u_div_s (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(rt_vld_q[32]),
    .dividend_i({rt_rho, {FRAC_BITS{1'b0}}}), .divisor_i(rt_rdiv),
    .side_i(rt_r),
    .valid_o(us_vld[3]), .quot_o(us_s), .ovf_o(us_ovf[3]), .side_o(us_r)
  );

  // ---------------------------------------------------------------- R0^2 * s
  logic               p1_vld_q, p2_vld_q;
  logic [2:0][UW-1:0] p1_um_q, p2_um_q;
  logic [2:0]         p1_neg_q, p2_neg_q;
  logic               p1_org_q, p2_org_q;
  logic               p1_clip_q, p2_clip_q;
  logic [63:0]        p1_r2_q, p2_r2_q;
  logic [31:0]        p1_r_q, p2_r_q;
  logic [31+UW-1:0]   p1_lo_q, p1_hi_q;
  logic [PW-1:0]      p2_prod_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_um_q   <= us_um;
      p1_neg_q  <= us_negorg[3:1];
      p1_org_q  <= us_negorg[0];
      p1_clip_q <= |us_ovf;
      p1_r2_q   <= {us_r2_hi, us_r2_lo};
      p1_r_q    <= us_r;
      p1_lo_q   <= (31 + UW)'(r0sq_q[30:0]) * (31 + UW)'(us_s);
      p1_hi_q   <= (31 + UW)'(r0sq_q[61:31]) * (31 + UW)'(us_s);

      p2_um_q   <= p1_um_q;
      p2_neg_q  <= p1_neg_q;
      p2_org_q  <= p1_org_q;
      p2_clip_q <= p1_clip_q;
      p2_r2_q   <= p1_r2_q;
      p2_r_q    <= p1_r_q;
      p2_prod_q <= PW'(p1_lo_q) + (PW'(p1_hi_q) << 31);
    end
  end

  // ---------------------------------------------------------------- C1 and q dividers
  logic            dq_vld, dc1_vld;
  logic [QB-1:0]   dq_quot, dc1_quot;
  logic            dq_ovf, dc1_ovf;
  logic [3*UW-1:0] dq_um;
  logic [4:0]      dc1_side;

  smf_div #(.DW(PW), .VW(32), .QW(QB), .SW(3 * UW)) u_div_q (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(p2_vld_q),
    .dividend_i(p2_prod_q), .divisor_i(p2_org_q ? 32'd1 : p2_r_q),
    .side_i(p2_um_q),
    .valid_o(dq_vld), .quot_o(dq_quot), .ovf_o(dq_ovf), .side_o(dq_um)
  );

  smf_div #(.DW(62 + FRAC_BITS), .VW(64), .QW(QB), .SW(5)) u_div_c1 (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(p2_vld_q),
    .dividend_i({r0sq_q, {FRAC_BITS{1'b0}}}), .divisor_i(p2_org_q ? 64'd1 : p2_r2_q),
    .side_i({p2_neg_q, p2_org_q, p2_clip_q}),
    .valid_o(dc1_vld), .quot_o(dc1_quot), .ovf_o(dc1_ovf), .side_o(dc1_side)
  );

  // ---------------------------------------------------------------- hold at 2^61, q * |Omega|
  logic               k1_vld_q, m1_vld_q, m2_vld_q;
  logic [MG-1:0]      k1_q_q;
  c2_side_t           k1_side_q, m1_side_q, m2_side_q;
  logic [62:0]        m1_lo_q, m1_hi_q;
  logic [93:0]        m2_prod_q;
  logic               c1_cap, q_cap;

  assign c1_cap = dc1_ovf || (dc1_quot > smf_pkg::CAP);
  assign q_cap  = dq_ovf  || (dq_quot  > smf_pkg::CAP);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      k1_q_q         <= q_cap  ? smf_pkg::CAP : dq_quot;
      k1_side_q.c1   <= c1_cap ? smf_pkg::CAP : dc1_quot;
      k1_side_q.um   <= dq_um;
      k1_side_q.neg  <= dc1_side[4:2];
      k1_side_q.org  <= dc1_side[1];
      k1_side_q.clip <= dc1_side[0] | c1_cap | q_cap;

      m1_lo_q   <= 63'(k1_q_q[30:0]) * 63'(ommag);
      m1_hi_q   <= 63'(k1_q_q[61:31]) * 63'(ommag);
      m1_side_q <= k1_side_q;

      m2_prod_q <= 94'(m1_lo_q) + (94'(m1_hi_q) << 31);
      m2_side_q <= m1_side_q;
    end
  end

  // ---------------------------------------------------------------- C2 divider
  logic          dc2_vld;
  logic [QB-1:0] dc2_quot;
  logic          dc2_ovf;
  c2_side_t      dc2_side;

  smf_div #(.DW(94), .VW(VF), .QW(QB), .SW($bits(c2_side_t))) u_div_c2 (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(m2_vld_q),
    .dividend_i(m2_prod_q), .divisor_i(vwf_q),
    .side_i(m2_side_q),
    .valid_o(dc2_vld), .quot_o(dc2_quot), .ovf_o(dc2_ovf), .side_o(dc2_side)
  );

  // ---------------------------------------------------------------- terms and components
  logic               c2_cap;
  logic               k2_vld_q, t1_vld_q, t2_vld_q, c_vld_q, d_vld_q, f1_vld_q, f2_vld_q;
  logic [MG-1:0]      k2_c2_q;
  c2_side_t           k2_side_q;
  logic [2:0]         t1_neg_q, t2_neg_q;
  logic               t1_org_q, t2_org_q, t1_clip_q, t2_clip_q;
  logic [4:0][31+UW-1:0] t1_lo_q, t1_hi_q;
  logic [4:0][MG-1:0] t2_m_q;
  logic [4:0][MG-1:0] tm;
  logic [4:0][MG-1:0] ta;
  logic [4:0][UW-1:0] tb;

  assign c2_cap = dc2_ovf || (dc2_quot > smf_pkg::CAP);

  // Radial terms for x, y, z; azimuthal terms use uy for x and ux for y.
  assign ta = {k2_c2_q, k2_c2_q, k2_side_q.c1, k2_side_q.c1, k2_side_q.c1};
  assign tb = {k2_side_q.um[0], k2_side_q.um[1],
               k2_side_q.um[2], k2_side_q.um[1], k2_side_q.um[0]};

  for (genvar j = 0; j < 5; j++) begin : g_term
    logic [TW-1:0] full;
    assign full  = TW'(t1_lo_q[j]) + (TW'(t1_hi_q[j]) << 31);
    assign tm[j] = full[FRAC_BITS +: MG];
  end

  logic [2:0] c_zneg_q;
  logic       c_org_q, c_clip_q;
  logic signed [2:0][63:0] c_comp_q;
  logic [2:0][62:0] d_mag_q;
  logic [2:0] d_oneg_q, f1_oneg_q, f2_oneg_q;
  logic       d_org_q, d_clip_q, f1_org_q, f1_clip_q, f2_org_q, f2_clip_q;
  logic [2:0][63:0] f1_lo_q;
  logic [2:0][62:0] f1_hi_q;
  logic [2:0][94:0] f2_m_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      k2_c2_q        <= c2_cap ? smf_pkg::CAP : dc2_quot;
      k2_side_q.c1   <= dc2_side.c1;
      k2_side_q.um   <= dc2_side.um;
      k2_side_q.neg  <= dc2_side.neg;
      k2_side_q.org  <= dc2_side.org;
      k2_side_q.clip <= dc2_side.clip | c2_cap;

      for (int j = 0; j < 5; j++) begin
        t1_lo_q[j] <= (31 + UW)'(ta[j][30:0]) * (31 + UW)'(tb[j]);
        t1_hi_q[j] <= (31 + UW)'(ta[j][61:31]) * (31 + UW)'(tb[j]);
      end
      t1_neg_q  <= k2_side_q.neg;
      t1_org_q  <= k2_side_q.org;
      t1_clip_q <= k2_side_q.clip;

      t2_m_q    <= tm;
      t2_neg_q  <= t1_neg_q;
      t2_org_q  <= t1_org_q;
      t2_clip_q <= t1_clip_q;

      // Azimuthal direction is (-uy, ux, 0).
      c_comp_q[0] <= smf_pkg::apply_sign(t2_m_q[0], t2_neg_q[0])
                   + smf_pkg::apply_sign(t2_m_q[3], c2neg ^ ~t2_neg_q[1]);
      c_comp_q[1] <= smf_pkg::apply_sign(t2_m_q[1], t2_neg_q[1])
                   + smf_pkg::apply_sign(t2_m_q[4], c2neg ^ t2_neg_q[0]);
      c_comp_q[2] <= smf_pkg::apply_sign(t2_m_q[2], t2_neg_q[2]);
      c_zneg_q    <= {3{t2_neg_q[2]}};
      c_org_q     <= t2_org_q;
      c_clip_q    <= t2_clip_q;

      // Flip for z < 0 and for a negative B0.
      for (int i = 0; i < 3; i++) begin
        d_mag_q[i]  <= c_comp_q[i][63] ? 63'(-c_comp_q[i]) : 63'(c_comp_q[i]);
        d_oneg_q[i] <= c_comp_q[i][63] ^ c_zneg_q[i] ^ b0_q[31];
      end
      d_org_q  <= c_org_q;
      d_clip_q <= c_clip_q;

      for (int i = 0; i < 3; i++) begin
        f1_lo_q[i] <= 64'(d_mag_q[i][31:0]) * 64'(b0mag);
        f1_hi_q[i] <= 63'(d_mag_q[i][62:32]) * 63'(b0mag);
      end
      f1_oneg_q <= d_oneg_q;
      f1_org_q  <= d_org_q;
      f1_clip_q <= d_clip_q;

      for (int i = 0; i < 3; i++) begin
        f2_m_q[i] <= 95'(f1_lo_q[i]) + (95'(f1_hi_q[i]) << 32);
      end
      f2_oneg_q <= f1_oneg_q;
      f2_org_q  <= f1_org_q;
      f2_clip_q <= f1_clip_q;
    end
  end

  // ---------------------------------------------------------------- saturate and drive result
  logic [2:0][31:0] sat_v;
  logic [2:0]       sat_c;
  logic [95:0]      out_data_q;
  logic [1:0]       out_user_q;

  for (genvar i = 0; i < 3; i++) begin : g_sat
    logic [OW-1:0] mm;
    assign mm = f2_m_q[i][94:FRAC_BITS];
    always_comb begin
      sat_c[i] = 1'b0;
      sat_v[i] = 32'(-mm[31:0]);
      if (f2_oneg_q[i]) begin
        if (mm > OW'(33'h0_8000_0000)) begin
          sat_c[i] = 1'b1;
          sat_v[i] = 32'h8000_0000;
        end
      end else if (mm > OW'(33'h0_7FFF_FFFF)) begin
        sat_c[i] = 1'b1;
        sat_v[i] = 32'h7FFF_FFFF;
      end else begin
        sat_v[i] = mm[31:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (f2_org_q) begin
        out_data_q <= '0;
        out_user_q <= 2'b01;
      end else begin
        out_data_q <= sat_v;
        out_user_q <= {f2_clip_q | (|sat_c), 1'b0};
      end
    end
  end

  // ---------------------------------------------------------------- valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      rt_vld_q  <= '0;
      p1_vld_q  <= 1'b0;
      p2_vld_q  <= 1'b0;
      k1_vld_q  <= 1'b0;
      m1_vld_q  <= 1'b0;
      m2_vld_q  <= 1'b0;
      k2_vld_q  <= 1'b0;
      t1_vld_q  <= 1'b0;
      t2_vld_q  <= 1'b0;
      c_vld_q   <= 1'b0;
      d_vld_q   <= 1'b0;
      f1_vld_q  <= 1'b0;
      f2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q  <= s_axis_tvalid;
      s2_vld_q  <= s1_vld_q;
      rt_vld_q  <= {rt_vld_q[31:0], s2_vld_q};
      p1_vld_q  <= &us_vld;
      p2_vld_q  <= p1_vld_q;
      k1_vld_q  <= dq_vld & dc1_vld;
      m1_vld_q  <= k1_vld_q;
      m2_vld_q  <= m1_vld_q;
      k2_vld_q  <= dc2_vld;
      t1_vld_q  <= k2_vld_q;
      t2_vld_q  <= t1_vld_q;
      c_vld_q   <= t2_vld_q;
      d_vld_q   <= c_vld_q;
      f1_vld_q  <= d_vld_q;
      f2_vld_q  <= f1_vld_q;
      out_vld_q <= f2_vld_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

`ifndef NO_ASSERTIONS
  // The two wide dividers run in lockstep.
  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dq_vld == dc1_vld)
    else $error("C1 and q dividers out of step");

  // A coordinate never exceeds the radius, so unit ratios never overflow.
  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&us_vld) |-> (us_ovf == '0))
    else $error("unit ratio overflow");

  // Cylindrical radius never exceeds the spherical radius.
  a_root_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rt_vld_q[32] |-> (rt_r >= rt_rho))
    else $error("rho above r");

  // Origin results are all zero and never flagged as clipped.
  a_origin_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0 && !m_axis_tuser[1]))
    else $error("origin result not zero");
`endif

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned FRAC = 16;
  localparam int unsigned LATENCY = 176 + FRAC;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 800;
  localparam logic [63:0] HELD_MAG = 64'(smf_pkg::CAP);

  typedef struct {
    logic [95:0] vec;
    logic [1:0]  flags;
  } field_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  // request: pos_x [31:0], pos_y [63:32], pos_z [95:64]
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  // result: field_x [31:0], field_y [63:32], field_z [95:64]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;
  // result flags: at_origin [0], clipped [1]
  logic [1:0]  m_axis_tuser;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [31:0] cfg_wdata_i = '0;

  spiral_magnetic_field_eval #(.FRAC_BITS(FRAC)) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Local copy of the register file, kept in step with every write
  logic signed [31:0] b0_copy = 32'sd65536;
  logic        [30:0] r0_copy = 31'd65536;
  logic signed [31:0] omega_copy = 32'sd0;
  logic        [30:0] vw_copy = 31'd65536;

  logic [95:0] pos_q[$];      // positions waiting to be offered
  field_t      field_q[$];    // predicted fields, oldest first
  bit          held_flag;     // set when some magnitude hit the cap or a component saturated
  bit          calm = 1'b0;   // suppress random idling on both sides
  bit          hold_start = 1'b0;
  bit          hold_used = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cycles = 0;
  int unsigned errors = 0;
  int unsigned n_sent = 0;
  int unsigned n_got = 0;
  int unsigned n_origin = 0;
  int unsigned n_clip = 0;

  // ---------------------------------------------------------------- predictor
  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bit_v;
    res = '0;
    bit_v = 64'd1 << 62;
    while (bit_v > n) bit_v >>= 2;
    while (bit_v != 0) begin
      if (n >= res + bit_v) begin
        n = n - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  // floor(a*b/c) from the exact product, held at the cap
  function automatic logic [63:0] scaled_quot(logic [63:0] a, logic [63:0] b,
                                              logic [63:0] c);
    logic [127:0] prod;
    logic [127:0] quo;
    prod = {64'd0, a} * {64'd0, b};
    if (c == 0) c = 64'd1;
    quo = prod / {64'd0, c};
    if (quo > {64'd0, HELD_MAG}) begin
      held_flag = 1'b1;
      return HELD_MAG;
    end
    return quo[63:0];
  endfunction

  function automatic longint signed_term(logic [63:0] m1, bit n1, logic [63:0] m2, bit n2);
    logic [63:0] m;
    m = scaled_quot(m1, m2, 64'd1 << FRAC);
    return (n1 != n2) ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic [63:0] abs64(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic field_t eval_field(logic [95:0] pos);
    field_t      res;
    longint      p[3];
    longint      comp[3];
    longint      v;
    logic [63:0] pm[3];
    logic [63:0] um[3];
    bit          un[3];
    logic [63:0] rho2, r2, r, rho, s, r0sq, c1, q, c2, vw;
    bit          c2neg, zneg;
    for (int i = 0; i < 3; i++) begin
      p[i] = longint'($signed(pos[32*i +: 32]));
      pm[i] = abs64(p[i]);
      un[i] = p[i] < 0;
    end
    rho2 = pm[0] * pm[0] + pm[1] * pm[1];
    r2 = rho2 + pm[2] * pm[2];
    if (r2 == 0) begin
      res.vec = '0;
      res.flags = 2'b01;
      return res;
    end
    held_flag = 1'b0;
    r = int_sqrt(r2);
    rho = int_sqrt(rho2);
    for (int i = 0; i < 3; i++) um[i] = (pm[i] << FRAC) / r;
    s = (rho << FRAC) / r;
    r0sq = 64'(r0_copy) * 64'(r0_copy);
    c1 = scaled_quot(r0sq, 64'd1 << FRAC, r2);
    q = scaled_quot(r0sq, s, r);
    vw = (vw_copy == 0) ? 64'd1 : 64'(vw_copy);
    c2 = scaled_quot(q, abs64(longint'(omega_copy)), vw << FRAC);
    c2neg = !(omega_copy < 0);
    for (int i = 0; i < 3; i++) comp[i] = signed_term(c1, 1'b0, um[i], un[i]);
    // azimuthal part along (-uy, ux, 0)
    comp[0] += signed_term(c2, c2neg, um[1], !un[1]);
    comp[1] += signed_term(c2, c2neg, um[0], un[0]);
    zneg = p[2] < 0;
    for (int i = 0; i < 3; i++) begin
      v = signed_term(abs64(comp[i]), (comp[i] < 0) != zneg,
                      abs64(longint'(b0_copy)), b0_copy < 0);
      if (v > 64'sh7FFF_FFFF) begin
        held_flag = 1'b1;
        v = 64'sh7FFF_FFFF;
      end else if (v < -64'sh8000_0000) begin
        held_flag = 1'b1;
        v = -64'sh8000_0000;
      end
      res.vec[32*i +: 32] = v[31:0];
    end
    res.flags = {held_flag, 1'b0};
    return res;
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0, 1: return $urandom();
      2: return 32'($signed(20'($urandom())));     // within about +-8.0
      3: return 32'($signed(26'($urandom())));     // within about +-512
      4: return $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(3)
                                  : 32'h8000_0000 + $urandom_range(3);
      default: return $urandom_range(2) == 0 ? 32'd0 : 32'($signed(8'($urandom())));
    endcase
  endfunction

  function automatic logic [31:0] rand_reg_val(bit is_unsigned);
    logic [31:0] v;
    case ($urandom_range(3))
      0: v = $urandom();
      1: v = 32'($signed(20'($urandom())));
      2: v = 32'($signed(24'($urandom())));
      default: v = $urandom_range(1) ? 32'd65536 : 32'd0;
    endcase
    return is_unsigned ? {1'b0, v[30:0]} : v;
  endfunction

  task automatic write_reg(smf_pkg::reg_idx_e idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      smf_pkg::REG_FIELD_SCALE:   b0_copy = val;
      smf_pkg::REG_REF_RADIUS:    r0_copy = val[30:0];
      smf_pkg::REG_ROTATION_RATE: omega_copy = val;
      smf_pkg::REG_WIND_SPEED:    vw_copy = val[30:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_all(logic [31:0] b0, logic [31:0] r0, logic [31:0] om,
                           logic [31:0] vw);
    write_reg(smf_pkg::REG_FIELD_SCALE, b0);
    write_reg(smf_pkg::REG_REF_RADIUS, r0);
    write_reg(smf_pkg::REG_ROTATION_RATE, om);
    write_reg(smf_pkg::REG_WIND_SPEED, vw);
  endtask

  task automatic queue_directed();
    logic [31:0] mx, mn;
    mx = 32'h7FFF_FFFF;
    mn = 32'h8000_0000;
    pos_q.push_back({32'd0, 32'd0, 32'd0});             // origin
    pos_q.push_back({32'd0, 32'd0, mx});
    pos_q.push_back({32'd0, 32'd0, mn});
    pos_q.push_back({32'd0, mx, 32'd0});
    pos_q.push_back({mn, 32'd0, 32'd0});
    pos_q.push_back({32'd0, 32'd0, 32'd1});             // one LSB off origin
    pos_q.push_back({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    pos_q.push_back({mx, mx, mx});
    pos_q.push_back({mn, mn, mn});
    pos_q.push_back({mn, mx, mn});
    pos_q.push_back({32'd0, 32'd0, 32'd65536});         // unit x
    pos_q.push_back({32'd0, 32'd65536, 32'd0});         // unit y
    pos_q.push_back({32'hFFFF_0000, 32'd0, 32'd0});     // unit z below plane
    pos_q.push_back({32'd65536, 32'd65536, 32'd65536});
    pos_q.push_back({32'hFFFF_0000, 32'hFFFF_0000, 32'd65536});
    pos_q.push_back({32'd0, 32'hFFFF_8000, 32'h0000_8000});
    pos_q.push_back({32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA});
    pos_q.push_back({32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555});
  endtask

  task automatic wait_drained();
    while (pos_q.size() != 0 || s_axis_tvalid || field_q.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------- driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
    end else begin
      // predict at acceptance: registers are steady while requests are in flight
      if (s_axis_tvalid && s_axis_tready) begin
        field_q.push_back(eval_field(s_axis_tdata));
        n_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pos_q.size() != 0 && (calm || $urandom_range(99) >= 20)) begin
          s_axis_tdata <= pos_q.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- back-pressure
  always @(posedge clk_i) begin
    if (hold_start && !hold_used) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  function automatic bit hold_start_pending();
    return hold_start && !hold_used;
  endfunction

  // ---------------------------------------------------------------- monitor
  task automatic report(string what, logic [95:0] got, logic [95:0] want);
    errors++;
    $display("mismatch %0s at cycle %0d: got %h expected %h", what, cycles, got, want);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    field_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= (hold_left == 0) && !hold_start_pending() &&
                       (calm || $urandom_range(99) >= 20);
      if (m_axis_tvalid && m_axis_tready) begin
        n_got++;
        if (field_q.size() == 0) begin
          report("unexpected result", m_axis_tdata, '0);
        end else begin
          want = field_q.pop_front();
          if (want.flags[0]) n_origin++;
          if (want.flags[1]) n_clip++;
          for (int i = 0; i < 3; i++)
            if (m_axis_tdata[32*i +: 32] !== want.vec[32*i +: 32])
              report($sformatf("field component %0d", i), 96'(m_axis_tdata[32*i +: 32]),
                     96'(want.vec[32*i +: 32]));
          if (m_axis_tuser[0] !== want.flags[0])
            report("at_origin", 96'(m_axis_tuser[0]), 96'(want.flags[0]));
          if (m_axis_tuser[1] !== want.flags[1])
            report("clipped", 96'(m_axis_tuser[1]), 96'(want.flags[1]));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_top failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values first, then extremes, then fixed settings, then random settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: ;
        1: write_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
        2: write_all(32'h8000_0000, 32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        3: write_all(32'd0, 32'd65536, 32'd196608, 32'd1);
        4: write_all(32'hFFFF_0000, 32'd131072, 32'hFFFE_8000, 32'd32768);
        default: write_all(rand_reg_val(1'b0), rand_reg_val(1'b1), rand_reg_val(1'b0),
                           rand_reg_val(1'b1));
      endcase
      if (ph == 0 || ph == 4) queue_directed();
      calm = (ph == 3);
      // stall the result side long enough to back the pipe up into the input
      if (ph == 5) hold_start = 1'b1;
      for (int k = 0; k < 150; k++) pos_q.push_back({rand_coord(), rand_coord(), rand_coord()});
      wait_drained();
    end

    repeat (LATENCY + 20) @(posedge clk_i);
    $display("covered %0d requests over 8 register settings incl. extremes and a %0d-cycle stall",
             n_sent, HOLD_CYCLES);
    $display("results checked %0d, origin cases %0d, saturated cases %0d",
             n_got, n_origin, n_clip);
    if (errors == 0 && field_q.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
